FILE: hdl/pdbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbc_pkg
// Shared types and constants for the pinch detector and balanced cut block.
// ----------------------------------------------------------------------------
package pdbc_pkg;

    // control sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_EMIT
    } state_t;

    // configuration register map
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RADIUS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_SPAN   = 1'b1;

    localparam int RADIUS_BITS = 6;
    localparam logic [RADIUS_BITS-1:0]   RADIUS_RESET = 6'd8;
    localparam logic [CFG_DATA_BITS-1:0] SPAN_RESET   = 32'd1;

    localparam int REGION_BITS = 15;
    localparam logic [REGION_BITS-1:0] REGION_MAX  = 15'h7fff;
    localparam logic [15:0]            REGION_NONE = 16'hffff;

    // commands into the max queue
    typedef struct packed {
        logic clear;
        logic trim_back;
        logic push;
        logic expire_front;
        logic rd_front;
    } q_cmd_t;

    // status out of the max queue
    typedef struct packed {
        logic empty;
        logic back_drop;
        logic front_stale;
    } q_stat_t;

    // one result item
    typedef struct packed {
        logic        pinch;
        logic        boundary;
        logic [15:0] region_id;
        logic        final_result;
    } res_t;

endpackage

FILE: hdl/pdbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbc_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pdbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/pdbc_maxq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbc_maxq
// Monotonic max queue kept in a circular RAM: back pops and pushes on entry,
// front expiry and front read on emit. Entries are {position, value}.
// ----------------------------------------------------------------------------
module pdbc_maxq #(
    parameter int VAL_BITS = 16,
    parameter int POS_BITS = 7,
    parameter int DEPTH    = 130
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pdbc_pkg::q_cmd_t       cmd,
    input  logic [VAL_BITS-1:0]    new_val,
    input  logic [POS_BITS-1:0]    new_pos,
    input  logic [POS_BITS-1:0]    span,
    output pdbc_pkg::q_stat_t      stat,
    output logic [VAL_BITS-1:0]    front_val
);

    import pdbc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = VAL_BITS + POS_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          fwd_reg, fwd_next;

    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic [EW-1:0] new_ent;
    logic [EW-1:0] front_ent;
    logic [POS_BITS-1:0] front_pos;
    logic [POS_BITS-1:0] age;

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - AW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.trim_back)
        begin
            tail_next  = addr_dec(tail_reg);
            count_next = count_reg - CW'(1);
        end
        else if (cmd.push)
        begin
            tail_next  = addr_inc(tail_reg);
            count_next = count_reg + CW'(1);
        end
        else if (cmd.expire_front)
        begin
            head_next  = addr_inc(head_reg);
            count_next = count_reg - CW'(1);
        end
    end

    // a push into an empty queue lands on the head the same cycle it is read
    assign fwd_next = cmd.push && (count_reg == '0);
    assign rd_addr  = cmd.rd_front ? head_next : addr_dec(tail_next);
    assign new_ent  = {new_pos, new_val};

    pdbc_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data (new_ent),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign front_ent = fwd_reg ? new_ent : rd_data;
    assign front_pos = front_ent[EW-1:VAL_BITS];
    assign front_val = front_ent[VAL_BITS-1:0];
    assign age       = new_pos - front_pos;

    assign stat.empty       = (count_reg == '0);
    assign stat.back_drop   = (count_reg != '0) && (rd_data[VAL_BITS-1:0] <= new_val);
    assign stat.front_stale = (age > span);

endmodule

FILE: hdl/pdbc_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbc_out
// Output register stage with valid/stall handshake.
// ----------------------------------------------------------------------------
module pdbc_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  pdbc_pkg::res_t res_in,
    output logic           free,
    output logic           out_valid,
    input  logic           out_stall,
    output pdbc_pkg::res_t res_out
);

    import pdbc_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

FILE: hdl/pinch_detect_balanced_cut.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinch_detect_balanced_cut
// Pinch detection over a coverage stream with balanced cut placement.
// ----------------------------------------------------------------------------
// Each coverage sample is written to a history ring and pushed into a
// monotonic max queue held in RAM; the result for a position leaves
// window_radius samples later, and the sample with last set flushes every
// pending position. An ordinary item passes through accept, queue push and
// emit, skipping emit while the first window_radius positions of a stream
// have no result yet; before the push, every queue entry no larger than the
// new sample is dropped from the back, and before each emit every expired
// entry is dropped from the front, one entry at a time through the single
// read port of the queue RAM. On average at most one entry per item is
// dropped from each end. The last item repeats emit for every other flushed
// position. The output register lets the next sample be taken while a result
// waits; beyond this processing the input stalls only when a new result finds
// that register still full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module pinch_detect_balanced_cut #(
    parameter int MAX_RADIUS    = 63,
    parameter int RING_DEPTH    = 128,
    parameter int COVERAGE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [0:0]               cfg_index,
    input  logic [31:0]              cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [COVERAGE_BITS-1:0] coverage,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     pinch,
    output logic                     boundary,
    output logic signed [15:0]       region_id,
    output logic                     final_result
);

    import pdbc_pkg::*;

    localparam int R_A   = (MAX_RADIUS < 63) ? MAX_RADIUS : 63;
    localparam int R_LIM = (R_A < (RING_DEPTH - 1) / 2) ? R_A : (RING_DEPTH - 1) / 2;
    localparam int RW    = (R_LIM > 0) ? $clog2(R_LIM + 1) : 1;
    localparam int PW    = $clog2(R_LIM + 2);
    localparam int AW    = $clog2(RING_DEPTH);
    localparam int QDEPTH = RING_DEPTH + 2;
    localparam logic [RADIUS_BITS-1:0] R_LIM_CFG = RADIUS_BITS'(R_LIM);
    localparam logic [AW-1:0] RING_LAST = AW'(RING_DEPTH - 1);

    // configuration
    logic [RADIUS_BITS-1:0]   rad_cfg_reg;
    logic [CFG_DATA_BITS-1:0] span_cfg_reg;

    // stream state
    state_t            state_reg, state_next;
    logic [RW-1:0]     radius_reg, radius_next;
    logic [COVERAGE_BITS-1:0] cov_reg, cov_next;
    logic              last_reg, last_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     newest_reg, newest_next;
    logic [AW-1:0]     npos_reg, npos_next;
    logic [PW-1:0]     pending_reg, pending_next;
    logic [RW-1:0]     left_reg, left_next;
    logic              started_reg, started_next;
    logic [31:0]       since_reg, since_next;
    logic [REGION_BITS-1:0] region_reg, region_next;

    logic [RW-1:0]     radius_limited;
    logic              ring_we;
    logic [AW-1:0]     ring_rd_addr;
    logic [COVERAGE_BITS-1:0] c_val;
    logic [AW:0]       cdiff;
    logic [AW:0]       span_w;
    logic [AW-1:0]     span;
    logic [31:0]       target;

    q_cmd_t            q_cmd;
    q_stat_t           q_stat;
    logic [COVERAGE_BITS-1:0] max_val;

    logic              res_load;
    logic              out_free;
    res_t              res_next;
    res_t              res_out;

    logic              pinch_hit;
    logic              is_bnd;
    logic              is_final;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_cfg_reg  <= RADIUS_RESET;
            span_cfg_reg <= SPAN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WINDOW_RADIUS: rad_cfg_reg  <= cfg_wdata[RADIUS_BITS-1:0];
                REG_TARGET_SPAN:   span_cfg_reg <= cfg_wdata;
            endcase
        end
    end

    assign radius_limited = (rad_cfg_reg > R_LIM_CFG) ? RW'(R_LIM_CFG) : RW'(rad_cfg_reg);
    assign target         = (span_cfg_reg == '0) ? 32'd1 : span_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            radius_reg  <= '0;
            last_reg    <= 1'b0;
            wr_ptr_reg  <= '0;
            newest_reg  <= '0;
            npos_reg    <= '0;
            pending_reg <= '0;
            left_reg    <= '0;
            started_reg <= 1'b0;
            since_reg   <= '0;
            region_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            radius_reg  <= radius_next;
            last_reg    <= last_next;
            wr_ptr_reg  <= wr_ptr_next;
            newest_reg  <= newest_next;
            npos_reg    <= npos_next;
            pending_reg <= pending_next;
            left_reg    <= left_next;
            started_reg <= started_next;
            since_reg   <= since_next;
            region_reg  <= region_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cov_reg <= cov_next;
    end

    // window for the oldest pending position: right part plus clipped left part
    assign span_w = (AW+1)'(pending_reg) - (AW+1)'(1) + (AW+1)'(left_reg);
    assign span   = span_w[AW-1:0];

    assign pinch_hit = (c_val >= max_val) && (c_val != '0);
    assign is_final  = last_reg && (pending_reg == PW'(1));
    assign is_bnd    = !started_reg || is_final || ((since_reg >= target) && pinch_hit);

    assign res_next.pinch        = pinch_hit;
    assign res_next.boundary     = is_bnd;
    assign res_next.region_id    = is_bnd ? REGION_NONE : {1'b0, region_reg};
    assign res_next.final_result = is_final;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        radius_next  = radius_reg;
        cov_next     = cov_reg;
        last_next    = last_reg;
        wr_ptr_next  = wr_ptr_reg;
        newest_next  = newest_reg;
        npos_next    = npos_reg;
        pending_next = pending_reg;
        left_next    = left_reg;
        started_next = started_reg;
        since_next   = since_reg;
        region_next  = region_reg;
        ring_we      = 1'b0;
        res_load     = 1'b0;
        q_cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cov_next     = coverage;
                    last_next    = last;
                    ring_we      = 1'b1;
                    newest_next  = wr_ptr_reg;
                    wr_ptr_next  = (wr_ptr_reg == RING_LAST) ? '0 : wr_ptr_reg + AW'(1);
                    npos_next    = npos_reg + AW'(1);
                    pending_next = pending_reg + PW'(1);
                    // radius is fixed for the whole stream
                    if (pending_reg == '0 && !started_reg)
                    begin
                        radius_next = radius_limited;
                    end
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                if (q_stat.back_drop)
                begin
                    q_cmd.trim_back = 1'b1;
                end
                else
                begin
                    q_cmd.push = 1'b1;
                    if (last_reg || (pending_reg > PW'(radius_reg)))
                    begin
                        q_cmd.rd_front = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT:
            begin
                q_cmd.rd_front = 1'b1;
                if (q_stat.front_stale)
                begin
                    q_cmd.expire_front = 1'b1;
                end
                else if (out_free)
                begin
                    res_load     = 1'b1;
                    pending_next = pending_reg - PW'(1);
                    started_next = 1'b1;
                    if (left_reg < radius_reg)
                    begin
                        left_next = left_reg + RW'(1);
                    end
                    if (is_bnd)
                    begin
                        if (started_reg && region_reg != REGION_MAX)
                        begin
                            region_next = region_reg + REGION_BITS'(1);
                        end
                        since_next = 32'd1;
                    end
                    else if (since_reg != '1)
                    begin
                        since_next = since_reg + 32'd1;
                    end

                    if (is_final)
                    begin
                        // end of stream: back to reset values
                        q_cmd.clear  = 1'b1;
                        pending_next = '0;
                        started_next = 1'b0;
                        left_next    = '0;
                        since_next   = '0;
                        region_next  = '0;
                        radius_next  = '0;
                        wr_ptr_next  = '0;
                        state_next   = ST_IDLE;
                    end
                    else if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ring index of the oldest pending position, for the next read
    assign cdiff = (AW+1)'(newest_next) - ((AW+1)'(pending_next) - (AW+1)'(1));
    assign ring_rd_addr = cdiff[AW] ? AW'(cdiff + (AW+1)'(RING_DEPTH)) : cdiff[AW-1:0];

    pdbc_ram #(
        .WIDTH (COVERAGE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (coverage),
        .rd_addr (ring_rd_addr),
        .rd_data (c_val)
    );

    pdbc_maxq #(
        .VAL_BITS (COVERAGE_BITS),
        .POS_BITS (AW),
        .DEPTH    (QDEPTH)
    ) u_maxq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .new_val   (cov_reg),
        .new_pos   (npos_reg),
        .span      (span),
        .stat      (q_stat),
        .front_val (max_val)
    );

    pdbc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res_in    (res_next),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign pinch        = res_out.pinch;
    assign boundary     = res_out.boundary;
    assign region_id    = signed'(res_out.region_id);
    assign final_result = res_out.final_result;

    // pending positions never exceed the window's right half plus the newest
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PW'(radius_reg) + PW'(1))
        else $error("pending count beyond radius");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= radius_reg)
        else $error("left window part beyond radius");

    // the newest sample always stays in the queue while emitting
    a_emit_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !q_stat.empty)
        else $error("max queue empty during emit");

    a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && is_final) |=> (q_stat.empty && pending_reg == '0 && !started_reg))
        else $error("stream state not cleared after final transfer");

endmodule

FILE: tb/pinch_detect_balanced_cut_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinch_detect_balanced_cut_tb
// Self-checking bench for the pinch detector and balanced cut block. A
// scoreboard class predicts every result of each accepted coverage sample
// and checks the output transfers in order. Stimulus covers short directed
// streams, a back-pressure burst, a run of back-to-back cuts and randomized
// streams with randomized register settings and random idling on both sides.
// ----------------------------------------------------------------------------
module pinch_detect_balanced_cut_tb;

    import pdbc_pkg::*;

    localparam int RING          = 128;
    localparam int MAX_R         = 63;
    localparam int CLIP_R        = (MAX_R < (RING - 1) / 2) ? MAX_R : (RING - 1) / 2;
    localparam int SETTLE_CYCLES = 300;
    localparam int LIMIT         = 300_000;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_ITEMS  = 380;
    localparam int CUT_RUN       = 20;

    class cut_scoreboard;
        logic [15:0] ring [RING];
        logic [5:0]  radius_reg;
        logic [31:0] span_reg;
        int unsigned lag;
        int unsigned wr_ptr;
        int unsigned pending;
        int unsigned emitted;
        int unsigned since_cut;
        logic [14:0] region;
        res_t        expected_q [$];
        int unsigned mismatches;
        int unsigned items;
        int unsigned streams;
        int unsigned results;
        int unsigned pinches;
        int unsigned cuts;
        int unsigned top_region;

        function new();
            radius_reg = RADIUS_RESET;
            span_reg   = SPAN_RESET;
            mismatches = 0;
            items      = 0;
            streams    = 0;
            results    = 0;
            pinches    = 0;
            cuts       = 0;
            top_region = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            lag       = 0;
            wr_ptr    = 0;
            pending   = 0;
            emitted   = 0;
            since_cut = 0;
            region    = '0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [31:0] data);
            if (idx == REG_WINDOW_RADIUS)
                radius_reg = data[RADIUS_BITS-1:0];
            else
                span_reg = data;
        endfunction

        // oldest pending position; newest is the slot just written
        function void emit_position(int unsigned newest, bit fin);
            int unsigned right;
            int unsigned left;
            int unsigned centre;
            int unsigned first;
            int unsigned peak;
            int unsigned tgt;
            int unsigned j;
            logic [15:0] c;
            bit          hit;
            bit          is_cut;
            res_t        r;
            right  = pending - 1;
            left   = (emitted < lag) ? emitted : lag;
            centre = (newest + RING - right) % RING;
            first  = (centre + RING - left) % RING;
            c      = ring[centre];
            peak   = 0;
            for (j = 0; j <= left + right; j++)
            begin
                if (ring[(first + j) % RING] > peak)
                    peak = ring[(first + j) % RING];
            end
            hit    = (c >= peak) && (c != 0);
            tgt    = (span_reg == 0) ? 1 : span_reg;
            is_cut = (emitted == 0) || fin || (since_cut >= tgt && hit);

            r.pinch        = hit;
            r.boundary     = is_cut;
            r.region_id    = is_cut ? REGION_NONE : {1'b0, region};
            r.final_result = fin;
            expected_q.insert(expected_q.size(), r);
            pinches += hit;
            cuts    += is_cut;

            if (is_cut)
            begin
                if (emitted != 0 && region != REGION_MAX)
                    region++;
                since_cut = 1;
            end
            else if (since_cut != 32'hFFFF_FFFF)
            begin
                since_cut++;
            end
            if (region > top_region)
                top_region = region;
            if (emitted != 32'hFFFF_FFFF)
                emitted++;
            pending--;
        endfunction

        function void note_input(logic [15:0] cov, logic lst);
            int unsigned newest;
            // radius is latched on the first sample of a stream
            if (pending == 0 && emitted == 0)
                lag = (radius_reg > CLIP_R) ? CLIP_R : radius_reg;
            newest       = wr_ptr;
            ring[newest] = cov;
            wr_ptr       = (newest + 1) % RING;
            pending++;
            items++;
            if (!lst)
            begin
                if (pending > lag)
                    emit_position(newest, 1'b0);
            end
            else
            begin
                while (pending > 0)
                    emit_position(newest, pending == 1);
                clear_stream();
                streams++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            results++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: pinch %0b boundary %0b region %0d final %0b",
                             got.pinch, got.boundary, $signed(got.region_id),
                             got.final_result);
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.pinch !== want.pinch || got.boundary !== want.boundary ||
                got.region_id !== want.region_id || got.final_result !== want.final_result)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d exp/act: pinch %0b/%0b bnd %0b/%0b %s %0d/%0d %s %0b/%0b",
                             results, want.pinch, got.pinch, want.boundary, got.boundary,
                             "region", $signed(want.region_id), $signed(got.region_id),
                             "final", want.final_result, got.final_result);
            end
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [0:0]          cfg_index    = '0;
    logic [31:0]         cfg_wdata    = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [15:0]         coverage     = '0;
    logic                last         = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                pinch;
    logic                boundary;
    logic signed [15:0]  region_id;
    logic                final_result;

    cut_scoreboard       sb;
    bit                  quiet        = 1'b0;
    int unsigned         hold_req     = 0;
    int unsigned         cycles       = 0;

    pinch_detect_balanced_cut u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .coverage     (coverage),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pinch        (pinch),
        .boundary     (boundary),
        .region_id    (region_id),
        .final_result (final_result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("pinch_detect_balanced_cut_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(res_t'({pinch, boundary, region_id, final_result}));
    end

    // result side: random stall before each transfer, long hold on request
    initial
    begin : result_side
        int unsigned n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req != 0)
            begin
                n        = hold_req;
                hold_req = 0;
                repeat (n)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                n = quiet ? 0 : $urandom_range(0, 17);
                repeat (n)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
                @(negedge clk);
                out_stall <= 1'b0;
                do @(posedge clk); while (!out_valid && hold_req == 0);
            end
        end
    end

    task automatic send_item(input logic [15:0] cov, input logic lst);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        coverage <= cov;
        last     <= lst;
        do @(posedge clk); while (in_stall);
        sb.note_input(cov, lst);
    endtask

    // wait until every expected transfer is seen and the block has gone quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic send_list(input logic [15:0] vals [$], input bit close);
        int i;
        for (i = 0; i < vals.size(); i++)
            send_item(vals[i], close && (i == vals.size() - 1));
    endtask

    function automatic logic [15:0] pick_coverage(int unsigned style);
        case (style)
            0:       return 16'($urandom_range(0, 3));
            1:       return 16'($urandom_range(0, 65535));
            default:
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    2:       return 16'h0001;
                    default: return 16'($urandom_range(0, 65535));
                endcase
        endcase
    endfunction

    task automatic send_stream(input int unsigned len, input int unsigned style,
                               input bit close);
        int unsigned i;
        for (i = 0; i < len; i++)
            send_item(pick_coverage(style), close && (i == len - 1));
    endtask

    function automatic logic [31:0] pick_radius();
        logic [31:0] r;
        case ($urandom_range(0, 4))
            0:       r = 0;
            1:       r = 1;
            2:       r = $urandom_range(2, 8);
            3:       r = 63;
            default: r = $urandom_range(0, 63);
        endcase
        // junk above the radius field must be ignored
        return ($urandom & 32'hFFFF_FFC0) | r;
    endfunction

    function automatic logic [31:0] pick_span();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd2;
            3:       return $urandom_range(3, 30);
            4:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic new_settings(input bit both);
        write_reg(REG_WINDOW_RADIUS, pick_radius());
        if (both || $urandom_range(0, 1))
            write_reg(REG_TARGET_SPAN, pick_span());
    endtask

    initial
    begin : stimulus
        int unsigned base;
        int unsigned len;
        int unsigned split;
        int unsigned style;
        int unsigned pick;
        int unsigned i;
        int unsigned errors;
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single-sample streams under reset settings
        send_list('{16'h0000}, 1'b1);
        send_list('{16'hFFFF}, 1'b1);
        settle();

        // zero radius, zero span behaves as span of one
        write_reg(REG_WINDOW_RADIUS, 32'd0);
        write_reg(REG_TARGET_SPAN, 32'd0);
        send_list('{16'hFFFF, 16'h0000, 16'h0001, 16'h0001, 16'h0000}, 1'b1);
        settle();

        // widest window, span never reached: whole stream flushed by last
        write_reg(REG_WINDOW_RADIUS, 32'd63);
        write_reg(REG_TARGET_SPAN, 32'hFFFF_FFFF);
        send_list('{16'd7, 16'hFFFF, 16'd3, 16'hFFFF, 16'd2}, 1'b1);
        settle();

        write_reg(REG_WINDOW_RADIUS, 32'd1);
        write_reg(REG_TARGET_SPAN, 32'd1);
        send_list('{16'h8000, 16'h5555, 16'hAAAA}, 1'b1);
        settle();

        // radius change mid-stream only applies to the next stream
        write_reg(REG_WINDOW_RADIUS, 32'd2);
        write_reg(REG_TARGET_SPAN, 32'd2);
        send_list('{16'd5, 16'd1, 16'd9}, 1'b0);
        settle();
        write_reg(REG_WINDOW_RADIUS, 32'd6);
        send_list('{16'd9, 16'd9, 16'd0, 16'd4}, 1'b1);
        settle();

        // long receiver hold while the sender keeps pushing
        write_reg(REG_WINDOW_RADIUS, 32'd3);
        write_reg(REG_TARGET_SPAN, 32'd4);
        quiet    = 1'b1;
        hold_req = 400;
        send_stream(80, 1, 1'b1);
        settle();

        // a cut on every positive position, then non-cut zero positions up to the final cut
        write_reg(REG_WINDOW_RADIUS, 32'd0);
        write_reg(REG_TARGET_SPAN, 32'd1);
        for (i = 0; i < CUT_RUN; i++)
            send_item(16'($urandom_range(1, 65535)), 1'b0);
        send_list('{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1);
        quiet = 1'b0;
        settle();

        base = sb.items;
        while (sb.items < base + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                settle();
                new_settings(1'b1);
            end
            quiet = ($urandom_range(0, 4) == 0);
            style = $urandom_range(0, 2);
            pick  = $urandom_range(0, 19);
            if (pick < 15)
                len = $urandom_range(1, 24);
            else if (pick < 19)
                len = $urandom_range(25, 80);
            else
                len = $urandom_range(129, 200);
            if (len > 3 && $urandom_range(0, 5) == 0)
            begin
                split = $urandom_range(1, len - 1);
                send_stream(split, style, 1'b0);
                settle();
                new_settings(1'b0);
                send_stream(len - split, style, 1'b1);
            end
            else
            begin
                send_stream(len, style, 1'b1);
            end
        end
        quiet = 1'b0;
        settle();

        $display("run covered %0d samples in %0d streams, %0d result transfers checked",
                 sb.items, sb.streams, sb.results);
        $display("predicted %0d pinches and %0d cuts, highest region number %0d",
                 sb.pinches, sb.cuts, sb.top_region);
        if (sb.expected_q.size() != 0)
            $display("%0d expected results never arrived", sb.expected_q.size());
        errors = sb.mismatches + sb.expected_q.size();
        if (errors == 0)
            $display("pinch_detect_balanced_cut_tb: clean");
        else
            $display("pinch_detect_balanced_cut_tb: errors");
        $finish;
    end

endmodule
